// ----- hw/rtl/slid_pkg.sv -----
// shared types for the sorted list block: operation and status codes,
// controller-to-datapath command and status bundles
// no dependencies
package slid_pkg;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_READ_ASC  = 2'd2,
    OP_READ_DESC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_ENTRY     = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  // commands from the controller
  typedef struct packed {
    logic    wr_insert;
    logic    wr_delete;
    logic    rd_start;
    logic    rd_desc;
    logic    rd_step;
    logic    out_load;
    logic    out_from_entry;
    status_t out_status;
    logic    out_last;
  } slid_cmd_t;

  // status back from the datapath
  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic rd_last;
  } slid_stat_t;

endpackage

// ----- hw/rtl/sorted_list_insert_delete.sv -----
// sorted list of up to CAPACITY signed 32-bit values kept in ascending order.
// insert places the value in front of the first entry that is not smaller,
// so it goes ahead of equal values; insert into a full list is dropped and
// reports full. delete removes the first equal entry or reports empty or not
// found. read ascending / descending streams every entry, the last marked;
// a read of an empty list gives one empty result. insert and delete write the
// cell chain as the request is taken, every cell comparing against the
// request value at once, and the next request is taken as soon as the
// output register is free. a read request sets up the read pointer, then
// one entry a cycle moves out of the cell chain into the output register
// while that register is free, with requests held off until the last entry
// has moved; out_ready low holds the stream. no clearing pass after reset.
// top level; depends on slid_pkg, slid_ctrl, slid_dp
module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_item_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status,
  output logic               out_last_result
);

  slid_cmd_t  cmd;
  slid_stat_t stat;

  // request decode, read sequencing, output valid
  slid_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // entry cells, count, read pointer, result register
  slid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .item_value       (in_item_value),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last_result  (out_last_result)
  );

endmodule

// ----- hw/rtl/slid_dp.sv -----
// datapath of the sorted list: cell chain of entries, entry count,
// read pointer and output result register; uses slid_pkg
module slid_dp
  import slid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slid_cmd_t          cmd,
  output slid_stat_t         stat,
  input  logic signed [31:0] item_value,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status,
  output logic               out_last_result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [31:0] entry_r   [CAPACITY];
  logic signed [31:0] ins_nxt   [CAPACITY];
  logic signed [31:0] del_nxt   [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      rd_left_r, rd_left_nxt;
  logic               rd_desc_r;
  logic [CAPACITY-1:0] in_use, lt, eq, first_eq, from_eq;
  logic signed [31:0] out_value_r;
  logic [2:0]         out_status_r;
  logic               out_last_r;

  // per-cell compares against the request value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign in_use[i] = CW'(i) < count_r;
    assign lt[i]     = in_use[i] && (entry_r[i] < item_value);
    assign eq[i]     = in_use[i] && (entry_r[i] == item_value);

    // insert: keep below the slot, drop value in, shift up above it
    if (i == 0) begin : g_ins0
      assign ins_nxt[i] = lt[i] ? entry_r[i] : item_value;
    end else begin : g_insn
      assign ins_nxt[i] = lt[i] ? entry_r[i] : (lt[i-1] ? item_value : entry_r[i-1]);
    end

    // delete: shift down from the first match on
    if (i == CAPACITY - 1) begin : g_dellast
      assign del_nxt[i] = entry_r[i];
    end else begin : g_deln
      assign del_nxt[i] = from_eq[i] ? entry_r[i+1] : entry_r[i];
    end

    always_ff @(posedge clk) begin
      if (cmd.wr_insert) begin
        entry_r[i] <= ins_nxt[i];
      end else if (cmd.wr_delete) begin
        entry_r[i] <= del_nxt[i];
      end
    end
  end

  // isolate first match, mask of cells at or above it
  assign first_eq = eq & (~eq + CAPACITY'(1));
  assign from_eq  = ~(first_eq - CAPACITY'(1));

  assign stat.full    = count_r == CW'(CAPACITY);
  assign stat.empty   = count_r == '0;
  assign stat.found   = |eq;
  assign stat.rd_last = rd_left_r == CW'(1);

  always_comb begin
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    rd_left_nxt = rd_left_r;
    if (cmd.wr_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.wr_delete) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.rd_start) begin
      rd_idx_nxt  = cmd.rd_desc ? IW'(count_r - CW'(1)) : '0;
      rd_left_nxt = count_r;
    end else if (cmd.rd_step) begin
      rd_idx_nxt  = rd_desc_r ? rd_idx_r - IW'(1) : rd_idx_r + IW'(1);
      rd_left_nxt = rd_left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    rd_left_r <= rd_left_nxt;
    if (cmd.rd_start) begin
      rd_desc_r <= cmd.rd_desc;
    end
    if (cmd.out_load) begin
      out_value_r  <= cmd.out_from_entry ? entry_r[rd_idx_r] : 32'sd0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last_result  = out_last_r;

endmodule

// ----- hw/rtl/slid_ctrl.sv -----
// controller of the sorted list: request decode, read streaming state
// and output valid; uses slid_pkg
module slid_ctrl
  import slid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  output logic       out_valid,
  input  logic       out_ready,
  input  slid_stat_t stat,
  output slid_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    cmd.out_status = STAT_DONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_INSERT: begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.wr_insert  = !stat.full;
              cmd.out_status = stat.full ? STAT_FULL : STAT_DONE;
            end
            OP_DELETE: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              priority if (stat.empty) begin
                cmd.out_status = STAT_EMPTY;
              end else if (!stat.found) begin
                cmd.out_status = STAT_NOT_FOUND;
              end else begin
                cmd.out_status = STAT_DONE;
                cmd.wr_delete  = 1'b1;
              end
            end
            OP_READ_ASC, OP_READ_DESC: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STAT_EMPTY;
              end else begin
                cmd.rd_start = 1'b1;
                cmd.rd_desc  = op_t'(in_operation) == OP_READ_DESC;
                state_nxt    = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.out_load       = 1'b1;
          cmd.out_from_entry = 1'b1;
          cmd.out_status     = STAT_ENTRY;
          cmd.out_last       = stat.rd_last;
          cmd.rd_step        = 1'b1;
          if (stat.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/slid_checker.sv -----
// port-level checks for the sorted list block, bound to the top level
// uses slid_pkg
module slid_checker
  import slid_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_result_value,
  input logic [2:0]         out_status,
  input logic               out_last_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)
      && $stable(out_status) && $stable(out_last_result))
    else $error("result changed while stalled");

  // every non-entry result is the only one of its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_ENTRY |-> out_last_result)
    else $error("status result not marked last");

  // status results carry zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_ENTRY |-> out_result_value == 32'sd0)
    else $error("status result with nonzero value");

  // a non-last entry is followed by another entry
  a_stream_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status == STAT_ENTRY && !out_last_result
      |=> !out_valid || out_status == STAT_ENTRY)
    else $error("read stream broken");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_last_result  (out_last_result)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for the sorted list block: a directed table, then
// random insert / delete / read requests checked against an in-bench predictor
// depends on slid_pkg and sorted_list_insert_delete
module tb_top;
  import slid_pkg::*;

  localparam int CAPACITY         = 16;
  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_PER_PHASE = 115;
  localparam int HOLD_OFF_CYCLES  = 200;
  // quiet stretch after the last owed result, for stray results
  localparam int DRAIN_CYCLES     = 40;
  // generous bound: every request a full read, every result a long stall
  localparam int TIMEOUT_CYCLES   = 1_500_000;

  // one result as the block should emit it
  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
    logic               last;
  } result_t;

  // one row of the directed table; reps repeats the row with value + k
  typedef struct {
    op_t                op;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    status_t            status;
  } step_t;

  localparam int NUM_DIRECTED = 24;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic signed [31:0] in_item_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_result_value;
  logic [2:0]         out_status;
  logic               out_last_result;

  // typed expectation that travels with the request on the table rows
  bit      req_typed;
  status_t req_status;

  // predictor state and the results still owed by the block
  logic signed [31:0] sorted_q [$];
  result_t            new_results [$];
  result_t            owed_q [$];
  result_t            want;

  // idling knobs shared with the receiver process
  int send_idle;
  int recv_idle;
  bit hold_pending;
  int hold_left;

  int fail_count;
  int requests_taken;
  int results_seen;
  int hit_full;
  int hit_empty;
  int hit_not_found;
  int longest_read;

  // directed part: empty list, extremes, duplicates, head and tail removal,
  // filling up to capacity and inserting into a full list
  step_t directed_steps [NUM_DIRECTED] = '{
    '{OP_READ_ASC,  32'sd0,          1,  1'b1, STAT_EMPTY},
    '{OP_READ_DESC, 32'sd0,          1,  1'b1, STAT_EMPTY},
    '{OP_DELETE,    32'sd5,          1,  1'b1, STAT_EMPTY},
    '{OP_INSERT,    32'sh7fff_ffff,  1,  1'b1, STAT_DONE},
    '{OP_INSERT,    32'sh8000_0000,  1,  1'b1, STAT_DONE},
    '{OP_INSERT,    32'sd0,          1,  1'b1, STAT_DONE},
    '{OP_INSERT,    -32'sd1,         1,  1'b1, STAT_DONE},
    '{OP_INSERT,    32'sd0,          1,  1'b1, STAT_DONE},
    '{OP_READ_ASC,  32'sd0,          1,  1'b0, STAT_DONE},
    '{OP_READ_DESC, 32'sd0,          1,  1'b0, STAT_DONE},
    '{OP_DELETE,    32'sd12345,      1,  1'b1, STAT_NOT_FOUND},
    '{OP_DELETE,    32'sh8000_0000,  1,  1'b1, STAT_DONE},
    '{OP_DELETE,    32'sd0,          1,  1'b1, STAT_DONE},
    '{OP_READ_ASC,  32'sd0,          1,  1'b0, STAT_DONE},
    '{OP_INSERT,    32'sd100,        13, 1'b1, STAT_DONE},
    '{OP_INSERT,    32'sd7,          1,  1'b1, STAT_FULL},
    '{OP_INSERT,    32'sh8000_0000,  1,  1'b1, STAT_FULL},
    '{OP_READ_DESC, 32'sd0,          1,  1'b0, STAT_DONE},
    '{OP_DELETE,    32'sh7fff_ffff,  1,  1'b1, STAT_DONE},
    '{OP_INSERT,    32'sh8000_0000,  1,  1'b1, STAT_DONE},
    '{OP_READ_ASC,  32'sd0,          1,  1'b0, STAT_DONE},
    '{OP_DELETE,    -32'sd1,         1,  1'b1, STAT_DONE},
    '{OP_DELETE,    32'sd100,        1,  1'b1, STAT_DONE},
    '{OP_READ_DESC, 32'sd0,          1,  1'b0, STAT_DONE}
  };

  sorted_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // list behavior for one request, appended to new_results
  function void list_results(input op_t op, input logic signed [31:0] v);
    int      pos;
    int      idx;
    result_t r;
    pos     = 0;
    r.value = '0;
    r.last  = 1'b1;
    case (op)
      OP_INSERT: begin
        if (sorted_q.size() >= CAPACITY) begin
          // full list drops the value
          r.status = STAT_FULL;
          hit_full++;
        end else begin
          // in front of the first entry that is not smaller
          while (pos < sorted_q.size() && sorted_q[pos] < v) pos++;
          sorted_q.insert(pos, v);
          r.status = STAT_DONE;
        end
        new_results.push_back(r);
      end
      OP_DELETE: begin
        if (sorted_q.size() == 0) begin
          r.status = STAT_EMPTY;
          hit_empty++;
        end else begin
          while (pos < sorted_q.size() && sorted_q[pos] != v) pos++;
          if (pos >= sorted_q.size()) begin
            r.status = STAT_NOT_FOUND;
            hit_not_found++;
          end else begin
            sorted_q.delete(pos);
            r.status = STAT_DONE;
          end
        end
        new_results.push_back(r);
      end
      default: begin
        if (sorted_q.size() == 0) begin
          // empty read still answers once
          r.status = STAT_EMPTY;
          hit_empty++;
          new_results.push_back(r);
        end else begin
          if (sorted_q.size() > longest_read) longest_read = sorted_q.size();
          for (int i = 0; i < sorted_q.size(); i++) begin
            idx      = (op == OP_READ_ASC) ? i : sorted_q.size() - 1 - i;
            r.value  = sorted_q[idx];
            r.status = STAT_ENTRY;
            r.last   = (i == sorted_q.size() - 1);
            new_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // offer one request, idling first, and return at the falling edge after it is taken
  task automatic send_request(input op_t op, input logic signed [31:0] v,
                              input bit typed, input status_t st);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_item_value <= v;
    req_typed     <= typed;
    req_status    <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off per phase so the block backs up
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // at each rising edge: predict for a taken request, then check a taken result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        requests_taken++;
        new_results.delete();
        list_results(op_t'(in_operation), in_item_value);
        if (req_typed) begin
          // table row with the answer typed in
          want.value  = '0;
          want.status = req_status;
          want.last   = 1'b1;
          owed_q.push_back(want);
        end else begin
          foreach (new_results[k]) owed_q.push_back(new_results[k]);
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_q.size() == 0) begin
          $error("unexpected result: value %0d status %0d last %0d",
                 out_result_value, out_status, out_last_result);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, out_result_value);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_last_result);
            fail_count++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int                 roll;
    int                 sz;
    bit                 filling;
    op_t                op;
    logic signed [31:0] v;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_INSERT;
    in_item_value = '0;
    req_typed     = 1'b0;
    req_status    = STAT_DONE;
    hold_pending  = 1'b0;
    send_idle     = 37;
    recv_idle     = 73;
    fail_count    = 0;
    filling       = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_steps[s]) begin
      for (int k = 0; k < directed_steps[s].reps; k++) begin
        send_request(directed_steps[s].op, directed_steps[s].value + k,
                     directed_steps[s].typed, directed_steps[s].status);
      end
    end

    // random phases: receiver slow, then sender slow, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 37;
          recv_idle = 73;
        end
        1: begin
          send_idle = 73;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      hold_pending = 1'b1;
      repeat (RANDOM_PER_PHASE) begin
        sz = sorted_q.size();
        // swing between filling up to capacity and draining to empty
        if (filling && sz >= CAPACITY && $urandom_range(2) == 0) filling = 1'b0;
        else if (!filling && sz == 0 && $urandom_range(2) == 0) filling = 1'b1;

        roll = $urandom_range(99);
        if (roll < 20) op = $urandom_range(1) ? OP_READ_ASC : OP_READ_DESC;
        else if (roll < (filling ? 75 : 35)) op = OP_INSERT;
        else op = OP_DELETE;

        // small values for duplicates, extremes, or anything at all
        case ($urandom_range(3))
          0, 1: v = int'($urandom_range(16)) - 8;
          2: begin
            case ($urandom_range(3))
              0: v = 32'sh7fff_ffff;
              1: v = 32'sh8000_0000;
              2: v = 32'sd0;
              default: v = -32'sd1;
            endcase
          end
          default: v = $urandom;
        endcase
        // deletes mostly hit an entry that is there
        if (op == OP_DELETE && sz > 0 && $urandom_range(9) < 7)
          v = sorted_q[$urandom_range(sz - 1)];

        send_request(op, v, 1'b0, STAT_DONE);
      end
    end
    in_valid <= 1'b0;

    // wait for every owed result, then a quiet stretch for stray ones
    while (owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, longest read %0d entries",
             requests_taken, results_seen, longest_read);
    $display("special answers predicted: %0d full, %0d empty, %0d not found",
             hit_full, hit_empty, hit_not_found);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
